@@ design/kdef_pkg.sv @@
// ----------------------------------------------------------------------------
// kdef_pkg: shared types and constants for the key debounce event FIFO
// Holds the field widths, reset values, register and function codes, and the
// helper that forms a key code.
// ----------------------------------------------------------------------------
package kdef_pkg;

    localparam int NUM_KEYS_DEFAULT   = 4;
    localparam int FIFO_DEPTH_DEFAULT = 16;

    localparam int FILTER_TIME_W  = 6;
    localparam int FILTER_COUNT_W = 7;
    localparam int HOLD_W         = 16;
    localparam int KEY_CODE_W     = 4;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int MAX_KEYS       = 16;

    localparam logic [FILTER_TIME_W-1:0]  FILTER_TIME_RESET     = 6'd5;
    localparam logic [HOLD_W-1:0]         LONG_PRESS_TIME_RESET = 16'd100;
    localparam logic [MAX_KEYS-1:0]       ACTIVE_HIGH_RESET     = 16'd8;
    // The filter counters start at half of the reset filter time.
    localparam logic [FILTER_COUNT_W-1:0] FILTER_COUNT_RESET    =
        FILTER_COUNT_W'(FILTER_TIME_RESET / 2);

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_READ = 1'b1
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FILTER_TIME      = 2'd0,
        REG_LONG_PRESS_TIME  = 2'd1,
        REG_ACTIVE_HIGH_MASK = 2'd2
    } reg_index_t;

    // Offsets added to 3k to form the code of key k.
    localparam int CODE_PRESS   = 1;
    localparam int CODE_RELEASE = 2;
    localparam int CODE_LONG    = 3;

    // Events raised by one key on one scan tick.
    typedef struct packed {
        logic press_evt;
        logic release_evt;
        logic long_evt;
    } key_evt_t;

    // Key code 3k + offset, kept to the low four bits for keys above four.
    function automatic logic [KEY_CODE_W-1:0] make_code(input int unsigned k,
                                                        input int unsigned offset);
        int unsigned v;
        v = 3 * k + offset;
        return v[KEY_CODE_W-1:0];
    endfunction

endpackage

@@ design/key_debounce_event_fifo.sv @@
// ----------------------------------------------------------------------------
// key_debounce_event_fifo: key debouncer with long-press events and code FIFO
// Takes one item per cycle while the result register is empty or being read; a read gives its result in the next cycle.
// Ticks update all key filters and the FIFO in the cycle they are accepted.
// Synchronous active-low reset loads the registers with their reset values,
// sets each filter count to half the reset filter time and empties the FIFO.
// ----------------------------------------------------------------------------
module key_debounce_event_fifo
    import kdef_pkg::*;
#(
    parameter int NUM_KEYS   = NUM_KEYS_DEFAULT,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic [CFG_INDEX_W-1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]                cfg_data,

    // Input items.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((NUM_KEYS + 7) / 8) * 8-1:0]  s_tdata,   // pin_levels
    input  logic [0:0]                           s_tuser,   // func

    // Result items.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata    // key_code
);

    localparam int NUM_SLOTS = 2 * NUM_KEYS;

    // Configuration registers.
    logic [FILTER_TIME_W-1:0] filter_time_reg;
    logic [HOLD_W-1:0]        long_press_time_reg;
    logic [NUM_KEYS-1:0]      active_high_mask_reg;

    logic                     m_tvalid_reg, m_tvalid_next;

    logic                     item_accept;
    logic                     tick_accept;
    logic                     read_accept;
    logic [NUM_KEYS-1:0]      key_pressed;
    key_evt_t                 key_evt [NUM_KEYS];

    logic [NUM_SLOTS-1:0]                 push;
    logic [NUM_SLOTS-1:0][KEY_CODE_W-1:0] push_code;
    logic [KEY_CODE_W-1:0]                rd_data;

    // Registers take a write in the cycle the enable is high. An index that
    // names no register is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_time_reg      <= FILTER_TIME_RESET;
            long_press_time_reg  <= LONG_PRESS_TIME_RESET;
            active_high_mask_reg <= ACTIVE_HIGH_RESET[NUM_KEYS-1:0];
        end else if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_FILTER_TIME: begin
                    filter_time_reg <= cfg_data[FILTER_TIME_W-1:0];
                end
                REG_LONG_PRESS_TIME: begin
                    long_press_time_reg <= cfg_data[HOLD_W-1:0];
                end
                REG_ACTIVE_HIGH_MASK: begin
                    active_high_mask_reg <= cfg_data[NUM_KEYS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The output register parts the two sides: a new item is taken whenever
    // the held result is gone or is being taken in this same cycle. Ticks
    // produce no result, and a read fills the register it has just made room in.
    assign s_tready    = !m_tvalid_reg || m_tready;
    assign item_accept = s_tvalid && s_tready;
    assign tick_accept = item_accept && (func_t'(s_tuser[0]) == FUNC_TICK);
    assign read_accept = item_accept && (func_t'(s_tuser[0]) == FUNC_READ);

    always_comb begin
        if (read_accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // One filter per key. A key counts as pressed when its pin level equals
    // its polarity bit.
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        assign key_pressed[k] = (s_tdata[k] == active_high_mask_reg[k]);

        kdef_key u_key (
            .aclk            (aclk),
            .aresetn         (aresetn),
            .tick            (tick_accept),
            .pressed         (key_pressed[k]),
            .filter_time     (filter_time_reg),
            .long_press_time (long_press_time_reg),
            .evt             (key_evt[k])
        );

        // Each key owns two FIFO slots in scan order: first the press or
        // release code (never both on one tick), then the long-press code.
        assign push[2*k]        = key_evt[k].press_evt || key_evt[k].release_evt;
        assign push_code[2*k]   = key_evt[k].press_evt ? make_code(k, CODE_PRESS)
                                                       : make_code(k, CODE_RELEASE);
        assign push[2*k+1]      = key_evt[k].long_evt;
        assign push_code[2*k+1] = make_code(k, CODE_LONG);
    end

    // The FIFO keeps one entry free to tell full from empty, so it holds at
    // most FIFO_DEPTH-1 codes. Codes beyond that on a tick are dropped. Its
    // read data register is the result register of this block.
    kdef_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .NUM_SLOTS  (NUM_SLOTS)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_code (push_code),
        .pop       (read_accept),
        .rd_data   (rd_data)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(8 - KEY_CODE_W){1'b0}}, rd_data};

endmodule

@@ design/kdef_key.sv @@
// ----------------------------------------------------------------------------
// kdef_key: hysteresis debounce filter and long-press timer for one key
// Updates its counters on each scan tick and reports the events that the tick
// raises in the same cycle.
// ----------------------------------------------------------------------------
module kdef_key
    import kdef_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     tick,
    input  logic                     pressed,
    input  logic [FILTER_TIME_W-1:0] filter_time,
    input  logic [HOLD_W-1:0]        long_press_time,
    output key_evt_t                 evt
);

    logic [FILTER_COUNT_W-1:0] filter_count_reg, filter_count_next;
    logic                      pressed_flag_reg, pressed_flag_next;
    logic [HOLD_W-1:0]         hold_count_reg, hold_count_next;

    logic [FILTER_COUNT_W-1:0] ft_ext;
    logic [FILTER_COUNT_W-1:0] ft_twice;
    logic [HOLD_W-1:0]         hold_inc;

    assign ft_ext   = {1'b0, filter_time};
    assign ft_twice = {filter_time, 1'b0};
    assign hold_inc = hold_count_reg + 1'b1;

    always_comb begin
        filter_count_next = filter_count_reg;
        pressed_flag_next = pressed_flag_reg;
        hold_count_next   = hold_count_reg;
        evt               = '0;
        if (tick) begin
            if (pressed) begin
                if (filter_count_reg < ft_ext) begin
                    filter_count_next = ft_ext;
                end else if (filter_count_reg < ft_twice) begin
                    filter_count_next = filter_count_reg + 1'b1;
                end else begin
                    // Settled pressed: report the press once, then time the hold.
                    if (!pressed_flag_reg) begin
                        pressed_flag_next = 1'b1;
                        evt.press_evt     = 1'b1;
                    end
                    if (long_press_time != '0 && hold_count_reg < long_press_time) begin
                        hold_count_next = hold_inc;
                        evt.long_evt    = (hold_inc == long_press_time);
                    end
                end
            end else begin
                if (filter_count_reg > ft_ext) begin
                    filter_count_next = ft_ext;
                end else if (filter_count_reg != '0) begin
                    filter_count_next = filter_count_reg - 1'b1;
                end else if (pressed_flag_reg) begin
                    pressed_flag_next = 1'b0;
                    evt.release_evt   = 1'b1;
                end
                hold_count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_count_reg <= FILTER_COUNT_RESET;
            pressed_flag_reg <= 1'b0;
            hold_count_reg   <= '0;
        end else begin
            filter_count_reg <= filter_count_next;
            pressed_flag_reg <= pressed_flag_next;
            hold_count_reg   <= hold_count_next;
        end
    end

endmodule

@@ design/kdef_fifo.sv @@
// ----------------------------------------------------------------------------
// kdef_fifo: ring buffer of key codes with several pushes per cycle
// Stores the pushed codes in slot order until full, drops the rest, and
// registers the oldest code (or zero when empty) on a pop.
// ----------------------------------------------------------------------------
module kdef_fifo
    import kdef_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT,
    parameter int NUM_SLOTS  = 2 * NUM_KEYS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [NUM_SLOTS-1:0]                  push,
    input  logic [NUM_SLOTS-1:0][KEY_CODE_W-1:0]  push_code,
    input  logic                                  pop,
    output logic [KEY_CODE_W-1:0]                 rd_data
);

    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int RANK_W = $clog2(NUM_SLOTS + 1);
    localparam int SUM_W  = ((PTR_W > RANK_W) ? PTR_W : RANK_W) + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(FIFO_DEPTH);
    localparam logic [SUM_W-1:0] LIMIT_S = SUM_W'(FIFO_DEPTH - 1);

    logic [KEY_CODE_W-1:0] store [FIFO_DEPTH];
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      count_reg, count_next;
    logic [KEY_CODE_W-1:0] rd_data_reg;

    logic [SUM_W-1:0]     free_s;
    logic [SUM_W-1:0]     rank   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] accept;
    logic [PTR_W-1:0]     slot   [NUM_SLOTS];
    logic [SUM_W-1:0]     n_push;
    logic [SUM_W-1:0]     n_acc;
    logic [SUM_W-1:0]     wr_sum;
    logic [SUM_W-1:0]     rd_sum;
    logic                 empty;
    logic                 pop_ok;

    function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] r;
        r = (v >= DEPTH_S) ? (v - DEPTH_S) : v;
        return r[PTR_W-1:0];
    endfunction

    assign empty  = (count_reg == '0);
    assign pop_ok = pop && !empty;
    assign free_s = LIMIT_S - SUM_W'(count_reg);

    // Each pushed code lands at the write pointer plus the number of codes
    // pushed ahead of it, as long as that stays within the free space.
    always_comb begin
        for (int j = 0; j < NUM_SLOTS; j++) begin
            rank[j]   = '0;
            for (int i = 0; i < j; i++) begin
                rank[j] = rank[j] + SUM_W'(push[i]);
            end
            accept[j] = push[j] && (rank[j] < free_s);
            slot[j]   = wrap(SUM_W'(wr_ptr_reg) + rank[j]);
        end
        n_push = SUM_W'($countones(push));
        n_acc  = (n_push < free_s) ? n_push : free_s;
        wr_sum = SUM_W'(wr_ptr_reg) + n_acc;
        rd_sum = SUM_W'(rd_ptr_reg) + SUM_W'(pop_ok);
        wr_ptr_next = wrap(wr_sum);
        rd_ptr_next = wrap(rd_sum);
        count_next  = PTR_W'(SUM_W'(count_reg) + n_acc - SUM_W'(pop_ok));
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < NUM_SLOTS; j++) begin
            if (accept[j]) begin
                store[slot[j]] <= push_code[j];
            end
        end
        if (pop) begin
            rd_data_reg <= empty ? '0 : store[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
